@@ hw/rtl/tpl_pkg.sv @@
// Shared types, constants and helpers for the track position to LED pixel core.
package tpl_pkg;

   localparam int BRIGHT_DIV = 4;
   localparam int CHAN_W     = 8;
   localparam int PIX_W      = 10;
   localparam int FRAC_W     = 4;
   localparam int POS_W      = 16;
   localparam int TLEN_W     = 16;
   localparam int LCNT_W     = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 40;
   localparam int NUM_ROWS   = 4;
   localparam int ROW_W      = 2;
   localparam logic [FRAC_W-1:0] FRAC_MAX = 4'd15;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LIGHT_COUNT  = 2'd0,
      CSR_TRACK_LENGTH = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } colour_type;

   // payload that rides along the divider stages
   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic             frame_end;
   } side_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_index;
      colour_type       colour;
   } pixel_type;

   localparam colour_type COLOUR_TABLE [NUM_ROWS] = '{
      '{red: 8'(0 / BRIGHT_DIV),   green: 8'(0 / BRIGHT_DIV),   blue: 8'(255 / BRIGHT_DIV)},
      '{red: 8'(127 / BRIGHT_DIV), green: 8'(0 / BRIGHT_DIV),   blue: 8'(63 / BRIGHT_DIV)},
      '{red: 8'(255 / BRIGHT_DIV), green: 8'(0 / BRIGHT_DIV),   blue: 8'(0 / BRIGHT_DIV)},
      '{red: 8'(255 / BRIGHT_DIV), green: 8'(255 / BRIGHT_DIV), blue: 8'(0 / BRIGHT_DIV)}
   };

   // (c * k) / 16, truncated
   function automatic logic [CHAN_W-1:0] scale_chan(input logic [CHAN_W-1:0] c,
                                                    input logic [FRAC_W-1:0] k);
      logic [CHAN_W+FRAC_W-1:0] prod;
      prod = CHAN_W'(c) * (CHAN_W+FRAC_W)'(k);
      return prod[CHAN_W+FRAC_W-1:FRAC_W];
   endfunction

   function automatic colour_type scale_colour(input colour_type c,
                                               input logic [FRAC_W-1:0] k);
      colour_type s;
      s.red   = scale_chan(c.red, k);
      s.green = scale_chan(c.green, k);
      s.blue  = scale_chan(c.blue, k);
      return s;
   endfunction

endpackage

@@ hw/rtl/tpl_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
module tpl_div_pipe #(
   parameter int STEPS = 16,
   parameter int RW    = 16,
   parameter int SW    = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [RW-1:0]    in_rem,     // starting partial remainder, below divisor
   input  logic [STEPS-1:0] in_bits,    // dividend bits still to bring down
   input  logic [RW-1:0]    divisor,
   input  logic [SW-1:0]    in_side,
   output logic             out_valid,
   output logic [STEPS-1:0] out_quot,
   output logic [RW-1:0]    out_rem,
   output logic [SW-1:0]    out_side
);

   logic             vld_src  [STEPS+1];
   logic [RW-1:0]    rem_src  [STEPS+1];
   logic [STEPS-1:0] bits_src [STEPS+1];
   logic [SW-1:0]    side_src [STEPS+1];

   assign vld_src[0]  = in_valid;
   assign rem_src[0]  = in_rem;
   assign bits_src[0] = in_bits;
   assign side_src[0] = in_side;

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [RW:0]      trial;
      logic             ge;
      logic [RW-1:0]    rem_in;
      logic [STEPS-1:0] bits_in;
      logic             vld_ff;
      logic [RW-1:0]    rem_ff;
      logic [STEPS-1:0] bits_ff;
      logic [SW-1:0]    side_ff;

      assign trial   = {rem_src[k], bits_src[k][STEPS-1]};
      assign ge      = trial >= {1'b0, divisor};
      assign rem_in  = ge ? RW'(trial - {1'b0, divisor}) : trial[RW-1:0];
      // quotient bits shift in from the bottom as dividend bits leave the top
      assign bits_in = {bits_src[k][STEPS-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (en) begin
            vld_ff <= vld_src[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff  <= rem_in;
            bits_ff <= bits_in;
            side_ff <= side_src[k];
         end
      end

      assign vld_src[k+1]  = vld_ff;
      assign rem_src[k+1]  = rem_ff;
      assign bits_src[k+1] = bits_ff;
      assign side_src[k+1] = side_ff;
   end

   assign out_valid = vld_src[STEPS];
   assign out_quot  = bits_src[STEPS];
   assign out_rem   = rem_src[STEPS];
   assign out_side  = side_src[STEPS];

endmodule

@@ hw/rtl/track_position_to_led_pixels_core.sv @@
// Runner position to LED pixel writes: top level with stream ports and register port.
// Each accepted position request yields two pixel writes, the next light first and then
// the light itself; the output port moves one write per cycle when the result side does
// not stall, and a new request is taken only while the output register is empty or as
// the second write of the last one leaves. The rate is set by those two writes sharing
// the one result port. On the way to its first write, a request passes an input
// register, a 16-stage position-modulo-track-length divider, one multiply stage, a
// second divider with one stage per bit of the scaled position, and the output register.
// The whole pipeline holds when the output stalls. Register writes are taken at any time
// outside reset but only while the pipeline is empty do they give defined results.
module track_position_to_led_pixels_core #(
   parameter int MAX_LIGHTS    = 1024,
   parameter int PARTNER_SLOTS = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [tpl_pkg::REQ_DATA_W-1:0]    req_tdata,   // [15:0] position
   input  logic [tpl_pkg::ROW_W-1:0]         req_tuser,   // [1:0] partner_slot
   input  logic                              req_tlast,   // frame_end
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [9:0] pixel_index, [17:10] red, [25:18] green, [33:26] blue, [39:34] zero
   output logic [tpl_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tuser,   // show_frame
   output logic                              rsp_tlast,   // last_of_item
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tpl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tpl_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int LW  = $clog2(MAX_LIGHTS + 1);
   localparam int CW  = (LW > tpl_pkg::LCNT_W) ? LW : tpl_pkg::LCNT_W;
   localparam int IW  = $clog2(MAX_LIGHTS);
   localparam int QW  = IW + tpl_pkg::FRAC_W;
   localparam int NW  = tpl_pkg::TLEN_W + LW + tpl_pkg::FRAC_W;
   localparam int SW  = $bits(tpl_pkg::side_type);

   // configuration registers
   logic [tpl_pkg::LCNT_W-1:0] light_count_ff;
   logic [tpl_pkg::TLEN_W-1:0] track_length_ff;
   logic [CW-1:0]              lcnt_ext;
   logic [LW-1:0]              lights;
   logic [tpl_pkg::TLEN_W-1:0] tlen;

   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         light_count_ff  <= tpl_pkg::LCNT_W'(100);
         track_length_ff <= tpl_pkg::TLEN_W'(4000);
      end else if (csr_valid) begin
         unique case (tpl_pkg::csr_index_type'(csr_index))
            tpl_pkg::CSR_LIGHT_COUNT:  light_count_ff  <= csr_data[tpl_pkg::LCNT_W-1:0];
            tpl_pkg::CSR_TRACK_LENGTH: track_length_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign lcnt_ext = CW'(light_count_ff);

   always_comb begin
      if (light_count_ff == '0) begin
         lights = LW'(1);
      end else if (lcnt_ext > CW'(MAX_LIGHTS)) begin
         lights = LW'(MAX_LIGHTS);
      end else begin
         lights = LW'(lcnt_ext);
      end
   end

   assign tlen = (track_length_ff == '0) ? tpl_pkg::TLEN_W'(1) : track_length_ff;

   // pipeline advance: output register empty or its second write leaving
   logic e_vld_ff;
   logic e_phase_ff;
   logic pipe_en;

   assign pipe_en    = !e_vld_ff || (e_phase_ff && rsp_tready);
   assign req_tready = pipe_en && !reset;

   // input register
   logic                        s0_vld_ff;
   logic [tpl_pkg::POS_W-1:0]   s0_pos_ff;
   tpl_pkg::side_type           s0_side_ff;
   tpl_pkg::side_type           s0_side_in;
   logic [tpl_pkg::ROW_W-1:0]   slot_row [tpl_pkg::NUM_ROWS];

   // colour row per slot, wrapped to the slot count
   for (genvar s = 0; s < tpl_pkg::NUM_ROWS; s++) begin : g_slot_row
      assign slot_row[s] = tpl_pkg::ROW_W'(s % PARTNER_SLOTS);
   end

   assign s0_side_in.row       = slot_row[req_tuser];
   assign s0_side_in.frame_end = req_tlast;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         s0_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s0_pos_ff  <= req_tdata[tpl_pkg::POS_W-1:0];
         s0_side_ff <= s0_side_in;
      end
   end

   // position mod track length
   logic                        da_vld;
   logic [tpl_pkg::POS_W-1:0]   da_quot;
   logic [tpl_pkg::TLEN_W-1:0]  da_rem;
   logic [SW-1:0]               da_side;

   tpl_div_pipe #(
      .STEPS (tpl_pkg::POS_W),
      .RW    (tpl_pkg::TLEN_W),
      .SW    (SW)
   ) u_div_mod (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (s0_vld_ff),
      .in_rem    ('0),
      .in_bits   (s0_pos_ff),
      .divisor   (tlen),
      .in_side   (s0_side_ff),
      .out_valid (da_vld),
      .out_quot  (da_quot),
      .out_rem   (da_rem),
      .out_side  (da_side)
   );

   // remainder times lights times 16
   logic          m_vld_ff;
   logic [NW-1:0] m_num_ff;
   logic [NW-1:0] m_num_in;
   logic [SW-1:0] m_side_ff;

   assign m_num_in = NW'({NW'(da_rem) * NW'(lights), 4'b0000});

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         m_vld_ff <= da_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         m_num_ff  <= m_num_in;
         m_side_ff <= da_side;
      end
   end

   // scaled position: the quotient fits in QW bits, so the top part starts below tlen
   logic                        db_vld;
   logic [QW-1:0]               db_quot;
   logic [tpl_pkg::TLEN_W-1:0]  db_rem;
   tpl_pkg::side_type           db_side;

   tpl_div_pipe #(
      .STEPS (QW),
      .RW    (tpl_pkg::TLEN_W),
      .SW    (SW)
   ) u_div_scale (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (m_vld_ff),
      .in_rem    (tpl_pkg::TLEN_W'(m_num_ff >> QW)),
      .in_bits   (m_num_ff[QW-1:0]),
      .divisor   (tlen),
      .in_side   (m_side_ff),
      .out_valid (db_vld),
      .out_quot  (db_quot),
      .out_rem   (db_rem),
      .out_side  (db_side)
   );

   // light index, wrap to the next light, colour scaling
   logic [IW-1:0]              idx;
   logic [tpl_pkg::FRAC_W-1:0] frac;
   logic [LW-1:0]              idx_inc;
   logic [IW-1:0]              nxt;
   tpl_pkg::colour_type        base;
   tpl_pkg::pixel_type         p_next_in;
   tpl_pkg::pixel_type         p_self_in;

   assign idx     = db_quot[QW-1:tpl_pkg::FRAC_W];
   assign frac    = db_quot[tpl_pkg::FRAC_W-1:0];
   assign idx_inc = LW'(idx) + LW'(1);
   assign nxt     = (idx_inc == lights) ? '0 : IW'(idx_inc);
   assign base    = tpl_pkg::COLOUR_TABLE[db_side.row];

   assign p_next_in.pixel_index = tpl_pkg::PIX_W'(nxt);
   assign p_next_in.colour      = tpl_pkg::scale_colour(base, frac);
   assign p_self_in.pixel_index = tpl_pkg::PIX_W'(idx);
   assign p_self_in.colour      = tpl_pkg::scale_colour(base, tpl_pkg::FRAC_MAX - frac);

   // output register holding both writes of one request
   tpl_pkg::pixel_type e_next_ff;
   tpl_pkg::pixel_type e_self_ff;
   logic               e_fend_ff;
   tpl_pkg::pixel_type out_pix;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff   <= 1'b0;
         e_phase_ff <= 1'b0;
      end else if (pipe_en) begin
         e_vld_ff   <= db_vld;
         e_phase_ff <= 1'b0;
      end else if (rsp_tready) begin
         e_phase_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         e_next_ff <= p_next_in;
         e_self_ff <= p_self_in;
         e_fend_ff <= db_side.frame_end;
      end
   end

   assign out_pix    = e_phase_ff ? e_self_ff : e_next_ff;
   assign rsp_tvalid = e_vld_ff;
   assign rsp_tlast  = e_phase_ff;
   assign rsp_tuser  = e_phase_ff & e_fend_ff;
   assign rsp_tdata  = tpl_pkg::RSP_DATA_W'({out_pix.colour.blue, out_pix.colour.green,
                                             out_pix.colour.red, out_pix.pixel_index});

   // checks
   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && rsp_tlast)
      else $error("second pixel write did not follow the first");

   a_show_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("show_frame on first pixel write");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      db_vld |-> LW'(idx) < lights && LW'(nxt) < lights)
      else $error("light index out of range");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      db_vld && !pipe_en |=> db_vld && $stable(db_quot))
      else $error("pipeline tail changed during stall");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      da_vld |-> da_rem < tlen)
      else $error("modulo stage remainder not below track length");

endmodule
